// File: hdl/rasc_pkg.sv
// Package for the rational add/sub/compare/reduce core: widths, codes, types.
// No dependencies.
package rasc_pkg;
  localparam int unsigned NUM_WIDTH = 64;
  localparam int unsigned DEN_WIDTH = 32;
  localparam int unsigned RDEN_WIDTH = DEN_WIDTH - 1;
  localparam int unsigned CNT_WIDTH = $clog2(NUM_WIDTH + 1);

  typedef enum logic [1:0] {
    KIND_MAKE = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_SUB  = 2'd2,
    KIND_CMP  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2
  } order_e;

  typedef struct packed {
    logic [1:0]           kind;
    logic [NUM_WIDTH-1:0] a_num;
    logic [DEN_WIDTH-1:0] a_den;
    logic [NUM_WIDTH-1:0] b_num;
    logic [DEN_WIDTH-1:0] b_den;
  } in_beat_t;

  typedef struct packed {
    logic [NUM_WIDTH-1:0]  res_num;
    logic [RDEN_WIDTH-1:0] res_den;
    logic [1:0]            order;
  } out_beat_t;

  // Request and reply between the sequencer and the shared divider.
  typedef struct packed {
    logic                 start;
    logic [NUM_WIDTH-1:0] dividend;
    logic [NUM_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [NUM_WIDTH-1:0] quot;
    logic [NUM_WIDTH-1:0] rem;
  } div_rsp_t;
endpackage

// File: hdl/rasc_if.sv
// Valid/ready channel interface carrying one beat of payload type T.
// No dependencies; the payload type T is a parameter.
interface rasc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/rasc_div.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on rasc_pkg.
module rasc_div import rasc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [NUM_WIDTH-1:0] quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [NUM_WIDTH:0]   trial;
  logic [NUM_WIDTH:0]   diff;

  assign trial = {rem_q, quot_q[NUM_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = CNT_WIDTH'(NUM_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[NUM_WIDTH]) begin
        rem_d  = diff[NUM_WIDTH-1:0];
        quot_d = {quot_q[NUM_WIDTH-2:0], 1'b1};
      end else begin
        rem_d  = trial[NUM_WIDTH-1:0];
        quot_d = {quot_q[NUM_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_WIDTH'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without busy");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider busy at done");
  a_cnt_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !req_i.start) |=> !busy_q) else $error("divider started itself");
endmodule

// File: hdl/rational_add_sub_compare_reduce_core.sv
// Top level: rational make/add/sub/compare with Euclid GCD reduction.
// Depends on rasc_pkg, rasc_if, rasc_div.
//
//  channel  dir  payload     handshake
//  in_if    in   in_beat_t   valid/ready
//  out_if   out  out_beat_t  valid/ready
//
// One item at a time; ready only while idle. Each GCD step and each final
// division is one pass of the shared divider. One operand build takes 3 to
// about 48 passes (Euclid remainders); make and compare do two builds, add
// and sub three, so 6 to about 150 passes. Cross products share one 32x32
// multiplier in two halves per 64x32 product; the denominator product uses
// its own. Reset clears the sequencer; a finished result holds until taken.
module rational_add_sub_compare_reduce_core import rasc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  rasc_if.sink   in_if,
  rasc_if.source out_if
);
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_LOAD  = 12'b000000000010,
    S_GSTEP = 12'b000000000100,
    S_GWAIT = 12'b000000001000,
    S_QNUM  = 12'b000000010000,
    S_QNWT  = 12'b000000100000,
    S_QDEN  = 12'b000001000000,
    S_QDWT  = 12'b000010000000,
    S_STORE = 12'b000100000000,
    S_MUL   = 12'b001000000000,
    S_COMB  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;

  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_R = 2'd2
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [1:0] kind_q;
  logic [NUM_WIDTH-1:0] bn_raw_q, an_q, bn_q, rn_q, x_q, y_q, mag_q, num_in_q;
  logic [DEN_WIDTH-1:0] bd_raw_q, ad_q, bd_q, rd_q, den_q, den_in_q;
  logic                 neg_q;
  logic [NUM_WIDTH-1:0] left_q, right_q, prod_q;
  logic [1:0]           mstep_q;
  logic [1:0]           order_q;
  logic                 out_valid_q;
  div_req_t             dreq;
  div_rsp_t             drsp;

  // Shared 32x32 multiplier, operands chosen by step.
  logic [31:0] mop_a, mop_b;
  logic [63:0] mres;
  assign mres = mop_a * mop_b;

  always_comb begin
    case (mstep_q)
      2'd0: begin mop_a = an_q[31:0];  mop_b = bd_q; end
      2'd1: begin mop_a = an_q[63:32]; mop_b = bd_q; end
      2'd2: begin mop_a = bn_q[31:0];  mop_b = ad_q; end
      default: begin mop_a = bn_q[63:32]; mop_b = ad_q; end
    endcase
  end

  rasc_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic                 den_bad;
  logic [NUM_WIDTH-1:0] gcd_v;
  assign den_bad = den_in_q[DEN_WIDTH-1] || (den_in_q == '0);
  assign gcd_v   = (x_q == '0) ? NUM_WIDTH'(1) : x_q;

  always_comb begin
    dreq = '0;
    case (state_q)
      S_GSTEP: begin
        dreq.start = 1'b1; dreq.dividend = x_q; dreq.divisor = y_q;
      end
      S_QNUM: begin
        dreq.start = 1'b1; dreq.dividend = mag_q; dreq.divisor = gcd_v;
      end
      S_QDEN: begin
        dreq.start = 1'b1; dreq.dividend = NUM_WIDTH'(den_q); dreq.divisor = gcd_v;
      end
      default: dreq = '0;
    endcase
  end

  assign in_if.ready  = (state_q == S_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.data  = '{res_num: rn_q, res_den: rd_q[RDEN_WIDTH-1:0], order: order_q};

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    case (state_q)
      S_IDLE:  if (in_if.valid) state_d = S_LOAD;
      S_LOAD:  state_d = S_GSTEP;
      S_GSTEP: state_d = (y_q == '0) ? S_QNUM : S_GWAIT;
      S_GWAIT: if (drsp.done) state_d = S_GSTEP;
      S_QNUM:  state_d = S_QNWT;
      S_QNWT:  if (drsp.done) state_d = S_QDEN;
      S_QDEN:  state_d = S_QDWT;
      S_QDWT:  if (drsp.done) state_d = S_STORE;
      S_STORE: begin
        case (phase_q)
          PH_A: begin phase_d = PH_B; state_d = S_LOAD; end
          PH_B: state_d = (kind_q == KIND_MAKE) ? S_OUT : S_MUL;
          default: state_d = S_OUT;
        endcase
      end
      S_MUL:   if (mstep_q == 2'd3) state_d = S_COMB;
      S_COMB: begin
        if (kind_q == KIND_CMP) begin
          state_d = S_OUT;
        end else begin
          phase_d = PH_R;
          state_d = S_LOAD;
        end
      end
      S_OUT:   if (out_valid_q && out_if.ready) begin
        state_d = S_IDLE;
        phase_d = PH_A;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_A;
      out_valid_q <= 1'b0;
      mstep_q     <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (state_q == S_MUL) mstep_q <= mstep_q + 1'b1;
      else mstep_q <= '0;
      if (state_q != S_OUT && state_d == S_OUT) out_valid_q <= 1'b1;
      else if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;
    end
  end

  logic [DEN_WIDTH-1:0]   den_prod;
  logic [NUM_WIDTH-1:0]   sum_v;
  logic [NUM_WIDTH-1:0]   lb, rb;
  assign den_prod = ad_q * bd_q;
  assign sum_v = (kind_q == KIND_ADD) ? left_q + right_q : left_q - right_q;
  assign lb = left_q ^ {1'b1, {(NUM_WIDTH-1){1'b0}}};
  assign rb = right_q ^ {1'b1, {(NUM_WIDTH-1){1'b0}}};

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (in_if.valid) begin
        kind_q   <= in_if.data.kind;
        num_in_q <= in_if.data.a_num;
        den_in_q <= in_if.data.a_den;
        bn_raw_q <= in_if.data.b_num;
        bd_raw_q <= in_if.data.b_den;
        order_q  <= ORD_LESS;
        rn_q     <= '0;
        rd_q     <= DEN_WIDTH'(1);
      end
      S_LOAD: begin
        neg_q <= num_in_q[NUM_WIDTH-1];
        mag_q <= num_in_q[NUM_WIDTH-1] ? -num_in_q : num_in_q;
        x_q   <= num_in_q[NUM_WIDTH-1] ? -num_in_q : num_in_q;
        y_q   <= den_bad ? NUM_WIDTH'(1) : NUM_WIDTH'(den_in_q);
        den_q <= den_bad ? DEN_WIDTH'(1) : den_in_q;
      end
      S_GWAIT: if (drsp.done) begin
        x_q <= y_q;
        y_q <= drsp.rem;
      end
      S_QNWT: if (drsp.done) mag_q <= neg_q ? -drsp.quot : drsp.quot;
      S_QDWT: if (drsp.done) den_q <= drsp.quot[DEN_WIDTH-1:0];
      S_STORE: begin
        case (phase_q)
          PH_A: begin
            an_q <= mag_q; ad_q <= den_q;
            num_in_q <= bn_raw_q; den_in_q <= bd_raw_q;
          end
          PH_B: begin
            bn_q <= mag_q; bd_q <= den_q;
            if (kind_q == KIND_MAKE) begin rn_q <= an_q; rd_q <= ad_q; end
          end
          default: begin rn_q <= mag_q; rd_q <= den_q; end
        endcase
      end
      S_MUL: begin
        case (mstep_q)
          2'd0: prod_q <= mres;
          2'd1: left_q <= prod_q + {mres[31:0], 32'b0};
          2'd2: prod_q <= mres;
          default: right_q <= prod_q + {mres[31:0], 32'b0};
        endcase
      end
      S_COMB: begin
        if (kind_q == KIND_CMP) begin
          order_q <= (lb < rb) ? ORD_LESS : ((lb == rb) ? ORD_EQUAL : ORD_GREATER);
        end else begin
          num_in_q <= sum_v;
          den_in_q <= den_prod;
        end
      end
      default: ;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !out_if.valid) else $error("ready while result pending");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> out_if.valid && $stable(out_if.data))
    else $error("result dropped");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
endmodule
